@@ src/eue_pkg.sv @@
// Shared constants for the ensemble uncertainty estimator.
package eue_pkg;

   localparam int WIDE_W = 64;
   localparam int FAC_W  = 18;

   localparam logic [FAC_W-1:0] FACTOR_ONE = 18'd65536;
   localparam logic [FAC_W-1:0] FACTOR_MAX = 18'd131072;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FEW      = 2'd1;
   localparam logic [1:0] STATUS_NOM_ZERO = 2'd2;

   localparam logic [1:0] MODE_PCT  = 2'd0;
   localparam logic [1:0] MODE_RMS  = 2'd1;
   localparam logic [1:0] MODE_HESS = 2'd2;
   localparam logic [1:0] MODE_ENV  = 2'd3;

   localparam logic REQ_NOMINAL = 1'b0;
   localparam logic REQ_SAMPLE  = 1'b1;

endpackage

@@ src/ensemble_uncertainty_estimator.sv @@
// Ensemble spread estimator: sample memory, scan passes, shared divider and square root.
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tdata sample_value, tuser req_type, tlast last_sample
//   rsp_     out  tvalid/tready      tdata relative_factor, tuser status
//   csr_     in   we (no wait)       wdata spread_mode
//
// Samples and nominal loads are accepted only while idle. After the last sample the
// block is busy with scans of the sample memory and, as the mode needs, the 64-step
// divider and the 32-step root.
// Synchronous reset clears the control state; the memory is not cleared.
// The result register lets the block take new requests while a result waits.
module ensemble_uncertainty_estimator
   import eue_pkg::*;
#(
   parameter int MAX_SAMPLES = 128,
   parameter int VALUE_BITS  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_value
   input  logic        req_tuser,   // [0] req_type
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] relative_factor, zero fill above
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata    // [1:0] spread_mode
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_RANK  = 4'd3;
   localparam logic [3:0] ST_PEND  = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_DDONE = 4'd6;
   localparam logic [3:0] ST_SQRT  = 4'd7;
   localparam logic [3:0] ST_FINAL = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   localparam logic [1:0] PASS_ENV  = 2'd0;
   localparam logic [1:0] PASS_SUM  = 2'd1;
   localparam logic [1:0] PASS_DEV  = 2'd2;
   localparam logic [1:0] PASS_HESS = 2'd3;

   localparam logic [1:0] DSEL_AVG = 2'd0;
   localparam logic [1:0] DSEL_VAR = 2'd1;
   localparam logic [1:0] DSEL_FAC = 2'd2;

   logic [VALUE_BITS-1:0] mem [MAX_SAMPLES];
   logic [VALUE_BITS-1:0] rd_a_ff, rd_b_ff;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [VALUE_BITS-1:0] nominal_ff, nominal_in;
   logic [CNT_W-1:0]      count_ff, count_in, q16_ff, q16_in, q84_ff, q84_in;
   logic [6:0]            r16_ff, r16_in, r84_ff, r84_in;
   logic [1:0]            pass_ff, pass_in, dsel_ff, dsel_in;
   logic [CNT_W-1:0]      idx_ff, idx_in, s1_idx_ff, s1_idx_in;
   logic [CNT_W-1:0]      outer_ff, outer_in, rank_ff, rank_in;
   logic                  iss_ff, iss_in, s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, min_ff, min_in, max_ff, max_in;
   logic [VALUE_BITS-1:0] avg_ff, avg_in;
   logic [WIDE_W-1:0]     acc_ff, acc_in, sq_ff, sq_in, spread_ff, spread_in;
   logic [WIDE_W-1:0]     dvd_ff, dvd_in, dvs_ff, dvs_in, quo_ff, quo_in;
   logic [WIDE_W:0]       rem_ff, rem_in;
   logic [5:0]            dcnt_ff, dcnt_in;
   logic [WIDE_W-1:0]     sx_ff, sx_in, sr_ff, sr_in, sbit_ff, sbit_in;
   logic [FAC_W-1:0]      res_fac_ff, res_fac_in, rsp_fac_ff, rsp_fac_in;
   logic [1:0]            res_st_ff, res_st_in, rsp_st_ff, rsp_st_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [WIDE_W-1:0]     req_wide;
   logic [VALUE_BITS-1:0] req_val, dref, dabs;
   logic [WIDE_W-1:0]     d64, sq_next, prod_sum_sqrt;
   logic [WIDE_W:0]       acc_sum, rem_sh;
   logic [7:0]            r16_sum, r84_sum;
   logic                  wr_en, accept, drained, rank_hit;

   assign req_wide = WIDE_W'(req_tdata);
   assign req_val  = req_wide[VALUE_BITS-1:0];
   assign accept   = req_tvalid && req_tready;
   assign wr_en    = accept && (req_tuser == REQ_SAMPLE) && (count_ff < CNT_MAX);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 24'(rsp_fac_ff);
   assign rsp_tuser  = rsp_st_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= req_val;
      end
      rd_a_ff <= mem[outer_ff[IDX_W-1:0]];
      rd_b_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      dref    = (pass_ff == PASS_DEV) ? avg_ff : nominal_ff;
      dabs    = (rd_b_ff >= dref) ? rd_b_ff - dref : dref - rd_b_ff;
      d64     = WIDE_W'(dabs);
      sq_next = (|d64[63:32]) ? '1 : d64[31:0] * d64[31:0];
      acc_sum = {1'b0, acc_ff} + {1'b0, sq_ff};
      rem_sh  = {rem_ff[WIDE_W-1:0], dvd_ff[WIDE_W-1]};
      prod_sum_sqrt = sr_ff + sbit_ff;
      r16_sum = {1'b0, r16_ff} + 8'd16;
      r84_sum = {1'b0, r84_ff} + 8'd84;
      drained = !iss_ff && !s1_vld_ff && !s2_vld_ff;
      rank_hit = (rd_b_ff < rd_a_ff) || ((rd_b_ff == rd_a_ff) && (s1_idx_ff < outer_ff));
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = csr_we ? csr_wdata : mode_ff;
      nominal_in = nominal_ff;
      count_in   = count_ff;
      q16_in     = q16_ff;
      q84_in     = q84_ff;
      r16_in     = r16_ff;
      r84_in     = r84_ff;
      pass_in    = pass_ff;
      dsel_in    = dsel_ff;
      idx_in     = idx_ff;
      iss_in     = iss_ff;
      s1_vld_in  = 1'b0;
      s1_idx_in  = idx_ff;
      s2_vld_in  = 1'b0;
      outer_in   = outer_ff;
      rank_in    = rank_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      avg_in     = avg_ff;
      acc_in     = acc_ff;
      sq_in      = sq_next;
      spread_in  = spread_ff;
      dvd_in     = dvd_ff;
      dvs_in     = dvs_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      sx_in      = sx_ff;
      sr_in      = sr_ff;
      sbit_in    = sbit_ff;
      res_fac_in = res_fac_ff;
      res_st_in  = res_st_ff;
      rsp_fac_in = rsp_fac_ff;
      rsp_st_in  = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // scan issue and pipeline, shared by the scan and rank states
      if ((state_ff == ST_SCAN) || (state_ff == ST_RANK)) begin
         if (iss_ff) begin
            s1_vld_in = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == count_ff - 1'b1) begin
               iss_in = 1'b0;
            end
         end
         if (s1_vld_ff) begin
            unique case (pass_ff)
               PASS_ENV: begin
                  if (rd_b_ff < min_ff) min_in = rd_b_ff;
                  if (rd_b_ff > max_ff) max_in = rd_b_ff;
               end
               PASS_SUM: acc_in = acc_ff + WIDE_W'(rd_b_ff);
               default:  s2_vld_in = 1'b1;
            endcase
            if (state_ff == ST_RANK && rank_hit) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         if (s2_vld_ff) begin
            acc_in = acc_sum[WIDE_W] ? '1 : acc_sum[WIDE_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_NOMINAL) begin
                  nominal_in = req_val;
                  count_in = '0;
                  q16_in = '0;
                  q84_in = '0;
                  r16_in = '0;
                  r84_in = '0;
               end else begin
                  if (wr_en) begin
                     count_in = count_ff + 1'b1;
                     if (r16_sum >= 8'd100) begin
                        r16_in = 7'(r16_sum - 8'd100);
                        q16_in = q16_ff + 1'b1;
                     end else begin
                        r16_in = r16_sum[6:0];
                     end
                     if (r84_sum >= 8'd100) begin
                        r84_in = 7'(r84_sum - 8'd100);
                        q84_in = q84_ff + 1'b1;
                     end else begin
                        r84_in = r84_sum[6:0];
                     end
                  end
                  if (req_tlast) begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            idx_in   = '0;
            iss_in   = 1'b1;
            acc_in   = '0;
            outer_in = '0;
            rank_in  = '0;
            min_in   = '1;
            max_in   = '0;
            if ((count_ff == '0) || ((mode_ff == MODE_PCT) && (q16_ff == '0)) ||
                ((mode_ff == MODE_RMS) && (count_ff < CNT_W'(2)))) begin
               res_fac_in = FACTOR_MAX;
               res_st_in  = STATUS_FEW;
               iss_in     = 1'b0;
               state_in   = ST_OUT;
            end else if (nominal_ff == '0) begin
               res_fac_in = FACTOR_MAX;
               res_st_in  = STATUS_NOM_ZERO;
               iss_in     = 1'b0;
               state_in   = ST_OUT;
            end else begin
               unique case (mode_ff)
                  MODE_PCT:  state_in = ST_RANK;
                  MODE_RMS:  begin pass_in = PASS_SUM;  state_in = ST_SCAN; end
                  MODE_HESS: begin pass_in = PASS_HESS; state_in = ST_SCAN; end
                  default:   begin pass_in = PASS_ENV;  state_in = ST_SCAN; end
               endcase
               if (mode_ff == MODE_PCT) begin
                  pass_in = PASS_ENV;
               end
            end
         end
         ST_SCAN: begin
            if (drained) begin
               unique case (pass_ff)
                  PASS_ENV: begin
                     spread_in = WIDE_W'((max_ff - min_ff) >> 1);
                     state_in  = ST_FINAL;
                  end
                  PASS_SUM: begin
                     dvd_in = acc_ff;
                     dvs_in = WIDE_W'(count_ff);
                     dsel_in = DSEL_AVG;
                     rem_in = '0;
                     quo_in = '0;
                     dcnt_in = '0;
                     state_in = ST_DIV;
                  end
                  PASS_DEV: begin
                     dvd_in = acc_ff;
                     dvs_in = WIDE_W'(count_ff - 1'b1);
                     dsel_in = DSEL_VAR;
                     rem_in = '0;
                     quo_in = '0;
                     dcnt_in = '0;
                     state_in = ST_DIV;
                  end
                  default: begin
                     sx_in = acc_ff;
                     sr_in = '0;
                     sbit_in = WIDE_W'(1) << 62;
                     state_in = ST_SQRT;
                  end
               endcase
            end
         end
         ST_RANK: begin
            if (drained) begin
               if (rank_ff == q16_ff - 1'b1) lo_in = rd_a_ff;
               if (rank_ff == q84_ff - 1'b1) hi_in = rd_a_ff;
               outer_in = outer_ff + 1'b1;
               rank_in  = '0;
               idx_in   = '0;
               if (outer_ff == count_ff - 1'b1) begin
                  state_in = ST_PEND;
               end else begin
                  iss_in = 1'b1;
               end
            end
         end
         ST_PEND: begin
            spread_in = WIDE_W'((hi_ff - lo_ff) >> 1);
            state_in  = ST_FINAL;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
            end
            dvd_in  = dvd_ff << 1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == '1) begin
               state_in = ST_DDONE;
            end
         end
         ST_DDONE: begin
            unique case (dsel_ff)
               DSEL_AVG: begin
                  avg_in  = quo_ff[VALUE_BITS-1:0];
                  acc_in  = '0;
                  idx_in  = '0;
                  iss_in  = 1'b1;
                  pass_in = PASS_DEV;
                  state_in = ST_SCAN;
               end
               DSEL_VAR: begin
                  sx_in = quo_ff;
                  sr_in = '0;
                  sbit_in = WIDE_W'(1) << 62;
                  state_in = ST_SQRT;
               end
               default: begin
                  res_fac_in = FACTOR_ONE + quo_ff[FAC_W-1:0];
                  res_st_in  = STATUS_OK;
                  state_in   = ST_OUT;
               end
            endcase
         end
         ST_SQRT: begin
            if (sbit_ff == '0) begin
               spread_in = sr_ff;
               state_in  = ST_FINAL;
            end else begin
               if (sx_ff >= prod_sum_sqrt) begin
                  sx_in = sx_ff - prod_sum_sqrt;
                  sr_in = (sr_ff >> 1) + sbit_ff;
               end else begin
                  sr_in = sr_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end
         end
         ST_FINAL: begin
            if (spread_ff >= WIDE_W'(nominal_ff)) begin
               res_fac_in = FACTOR_MAX;
               res_st_in  = STATUS_OK;
               state_in   = ST_OUT;
            end else begin
               dvd_in  = spread_ff << 16;
               dvs_in  = WIDE_W'(nominal_ff);
               dsel_in = DSEL_FAC;
               rem_in  = '0;
               quo_in  = '0;
               dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_fac_in   = res_fac_ff;
               rsp_st_in    = res_st_ff;
               rsp_valid_in = 1'b1;
               count_in = '0;
               q16_in   = '0;
               q84_in   = '0;
               r16_in   = '0;
               r84_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_PCT;
         nominal_ff   <= '0;
         count_ff     <= '0;
         q16_ff       <= '0;
         q84_ff       <= '0;
         r16_ff       <= '0;
         r84_ff       <= '0;
         iss_ff       <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         nominal_ff   <= nominal_in;
         count_ff     <= count_in;
         q16_ff       <= q16_in;
         q84_ff       <= q84_in;
         r16_ff       <= r16_in;
         r84_ff       <= r84_in;
         iss_ff       <= iss_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff    <= pass_in;
      dsel_ff    <= dsel_in;
      idx_ff     <= idx_in;
      s1_idx_ff  <= s1_idx_in;
      outer_ff   <= outer_in;
      rank_ff    <= rank_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      avg_ff     <= avg_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      spread_ff  <= spread_in;
      dvd_ff     <= dvd_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      sx_ff      <= sx_in;
      sr_ff      <= sr_in;
      sbit_ff    <= sbit_in;
      res_fac_ff <= res_fac_in;
      res_st_ff  <= res_st_in;
      rsp_fac_ff <= rsp_fac_in;
      rsp_st_ff  <= rsp_st_in;
   end

endmodule
